// ===== rtl/core/sdcr_pkg.sv =====
// sdcr_pkg: shared types, constants and helper functions for the damped comb reverb
// no dependencies; compiled first

package sdcr_pkg;

    localparam int DATA_W = 24;
    localparam int RATE_W = 18;
    localparam int COEF_W = 16;
    localparam int BASE_W = 12;
    localparam int PROD_W = BASE_W + RATE_W;
    localparam int QUOT_W = 15;
    localparam int ACC_W  = 43;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic        [RATE_W-1:0] t_rate;

    // transaction kinds on the input channel
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // damping and feed coefficients, unsigned Q0.16
    localparam logic [COEF_W-1:0] COEF_OLD = 16'd36045;
    localparam logic [COEF_W-1:0] COEF_TAP = 16'd29491;
    localparam logic [COEF_W-1:0] COEF_IN  = 16'd14418;
    localparam logic [COEF_W-1:0] COEF_FB  = 16'd41288;

    // rounding offset for the 16 bit product shift
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 43'sd32768;

    // ceil(2^32 / 375): x / 48000 == ((x >> 7) * RECIP_375) >> 32 for x < 2^30
    localparam logic [23:0] RECIP_375 = 24'd11453247;

    localparam t_rate RATE_RESET = 18'd48000;

    // datapath step commanded by the controller
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_LEN_MUL,
        STEP_LEN_DIV,
        STEP_ADDR,
        STEP_READ,
        STEP_DAMP_A,
        STEP_DAMP_B,
        STEP_DAMP_C,
        STEP_WRITE_A,
        STEP_WRITE_B
    } t_step;

    typedef struct packed {
        logic  capture;
        logic  clear_state;
        logic  load_out;
        t_step step;
    } t_dp_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEN_MUL,
        S_LEN_DIV,
        S_ADDR,
        S_READ,
        S_DAMP_A,
        S_DAMP_B,
        S_DAMP_C,
        S_WRITE_A,
        S_WRITE_B,
        S_DONE
    } t_ctrl_state;

    // base comb length at 48 kHz, by channel and line within a group of four
    function automatic logic [BASE_W-1:0] base_len(input logic ch, input logic [1:0] j);
        logic [BASE_W-1:0] len;
        unique case ({ch, j})
            3'b000:  len = 12'd1423;
            3'b001:  len = 12'd1559;
            3'b010:  len = 12'd1747;
            3'b011:  len = 12'd1999;
            3'b100:  len = 12'd1481;
            3'b101:  len = 12'd1613;
            3'b110:  len = 12'd1801;
            default: len = 12'd2081;
        endcase
        return len;
    endfunction

    // saturate to the signed 24 bit sample range
    function automatic t_sample sat24(input logic signed [27:0] x);
        t_sample y;
        if (x > 28'sd8388607) begin
            y = 24'sh7FFFFF;
        end else if (x < -28'sd8388608) begin
            y = 24'sh800000;
        end else begin
            y = x[DATA_W-1:0];
        end
        return y;
    endfunction

endpackage

// ===== rtl/core/sdcr_if.sv =====
// sdcr_if: valid/ready stream interfaces for the input and result channels
// depends on sdcr_pkg for the sample type

interface sdcr_in_if;
    logic              valid;
    logic              ready;
    logic              kind;
    sdcr_pkg::t_sample in_left;
    sdcr_pkg::t_sample in_right;

    modport source (output valid, output kind, output in_left, output in_right, input ready);
    modport sink   (input valid, input kind, input in_left, input in_right, output ready);
endinterface

interface sdcr_out_if;
    logic              valid;
    logic              ready;
    sdcr_pkg::t_sample out_left;
    sdcr_pkg::t_sample out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// ===== rtl/core/stereo_damped_comb_reverb.sv =====
// stereo_damped_comb_reverb: top level of the stereo lowpass-feedback comb reverb
// depends on sdcr_pkg, sdcr_if, sdcr_ctrl and sdcr_datapath
//
//   channel   dir   handshake       payload
//   i_in      in    valid/ready     kind, in_left, in_right (Q3.20)
//   o_out     out   valid/ready     out_left, out_right (Q3.20, saturated)
//   cfg       in    i_cfg_we        i_cfg_data = sample_rate (18 bits)
//
// a sample transaction takes each comb line in turn through the shared multiplier and the
// single-port delay store: length scaling, addressing, read, damping and write-back
// a clear transaction goes straight to the result; cursors, fill counts and damping values
// reset at once, and unwritten delay entries read as zero, so no clearing pass follows reset
// a finished result waits in the output register while the next transaction is taken;
// a stalled output only holds the sequencer once the next result is also finished

module stereo_damped_comb_reverb #(
    parameter int MAX_DELAY         = 2400,
    parameter int LINES_PER_CHANNEL = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  sdcr_pkg::t_rate  i_cfg_data,
    sdcr_in_if.sink          i_in,
    sdcr_out_if.source       o_out
);
    import sdcr_pkg::*;

    localparam int LINE_W = $clog2(2 * LINES_PER_CHANNEL);

    t_dp_cmd           w_cmd;
    logic [LINE_W-1:0] w_line;
    logic              w_in_ready;
    logic              w_out_valid;
    t_sample           w_out_left;
    t_sample           w_out_right;

    // line sequencer
    sdcr_ctrl #(
        .LINES_PER_CHANNEL (LINES_PER_CHANNEL)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .o_line      (w_line)
    );

    // delay store and arithmetic
    sdcr_datapath #(
        .MAX_DELAY         (MAX_DELAY),
        .LINES_PER_CHANNEL (LINES_PER_CHANNEL)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_line      (w_line),
        .i_in_left   (i_in.in_left),
        .i_in_right  (i_in.in_right),
        .o_out_left  (w_out_left),
        .o_out_right (w_out_right)
    );

    // channel connections
    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = w_out_valid;
    assign o_out.out_left  = w_out_left;
    assign o_out.out_right = w_out_right;

endmodule

// ===== rtl/core/sdcr_datapath.sv =====
// sdcr_datapath: delay store, line cursors, damping state, shared MAC and output register
// depends on sdcr_pkg; driven by sdcr_ctrl through t_dp_cmd and the line index

module sdcr_datapath #(
    parameter int MAX_DELAY         = 2400,
    parameter int LINES_PER_CHANNEL = 4,
    localparam int NUM_LINES        = 2 * LINES_PER_CHANNEL,
    localparam int LINE_W           = $clog2(NUM_LINES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  sdcr_pkg::t_rate       i_cfg_data,
    input  sdcr_pkg::t_dp_cmd     i_cmd,
    input  logic [LINE_W-1:0]     i_line,
    input  sdcr_pkg::t_sample     i_in_left,
    input  sdcr_pkg::t_sample     i_in_right,
    output sdcr_pkg::t_sample     o_out_left,
    output sdcr_pkg::t_sample     o_out_right
);
    import sdcr_pkg::*;

    localparam int POS_W  = $clog2(MAX_DELAY);
    localparam int DEPTH  = NUM_LINES * MAX_DELAY;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = DATA_W + $clog2(LINES_PER_CHANNEL) + 1;
    localparam logic [POS_W-1:0]  LEN_MAX = POS_W'(MAX_DELAY - 1);
    localparam logic [QUOT_W-1:0] QUOT_MAX = QUOT_W'(MAX_DELAY - 1);

    // configuration
    t_rate r_sample_rate;

    // per-line state: cursor, fill count, damping value
    logic [POS_W-1:0] r_pos  [NUM_LINES];
    logic [POS_W-1:0] r_fill [NUM_LINES];
    t_sample          r_damp [NUM_LINES];

    // delay store
    t_sample mem [DEPTH];
    t_sample r_rdata;

    // per-transaction and per-line working registers
    t_sample                    r_dry_l;
    t_sample                    r_dry_r;
    logic signed [SUM_W-1:0]    r_sum_l;
    logic signed [SUM_W-1:0]    r_sum_r;
    logic [PROD_W-1:0]          r_prod;
    logic [QUOT_W-1:0]          r_quot;
    logic [POS_W-1:0]           r_len;
    logic [POS_W-1:0]           r_cur_pos;
    logic [ADDR_W-1:0]          r_cur_addr;
    logic                       r_valid;
    t_sample                    r_tap;
    logic signed [ACC_W-1:0]    r_acc;
    t_sample                    r_out_left;
    t_sample                    r_out_right;

    logic                       w_ch;
    logic [LINE_W-1:0]          w_j;
    logic [POS_W-1:0]           w_len;
    logic [POS_W-1:0]           w_pos_eff;
    logic [POS_W:0]             w_pos_next;
    logic [ADDR_W-1:0]          w_addr;
    logic [46:0]                w_recip_prod;
    t_sample                    w_tap;
    logic [COEF_W-1:0]          w_coef;
    t_sample                    w_opnd;
    logic signed [40:0]         w_prod;
    t_sample                    w_wr_data;
    logic signed [SUM_W-1:0]    w_half_l;
    logic signed [SUM_W-1:0]    w_half_r;

    // channel and position of the line within its channel
    always_comb begin
        w_ch = (i_line >= LINE_W'(LINES_PER_CHANNEL));
        w_j  = w_ch ? (i_line - LINE_W'(LINES_PER_CHANNEL)) : i_line;
    end

    // clamp of the scaled length and cursor restart on a shortened line
    always_comb begin
        if (r_quot == '0) begin
            w_len = POS_W'(1);
        end else if (r_quot > QUOT_MAX) begin
            w_len = LEN_MAX;
        end else begin
            w_len = r_quot[POS_W-1:0];
        end
        w_pos_eff  = (r_pos[i_line] >= w_len) ? '0 : r_pos[i_line];
        w_addr     = ADDR_W'(i_line) * ADDR_W'(MAX_DELAY) + ADDR_W'(w_pos_eff);
        w_pos_next = {1'b0, r_cur_pos} + (POS_W+1)'(1);
    end

    assign w_recip_prod = 47'(r_prod[PROD_W-1:7]) * 47'(RECIP_375);

    // an entry past the line's fill count has never been written and reads as zero
    assign w_tap = r_valid ? r_rdata : '0;

    // shared multiplier operand selection
    always_comb begin
        unique case (i_cmd.step)
            STEP_DAMP_A: begin
                w_coef = COEF_OLD;
                w_opnd = r_damp[i_line];
            end
            STEP_DAMP_B: begin
                w_coef = COEF_TAP;
                w_opnd = r_tap;
            end
            STEP_DAMP_C: begin
                w_coef = COEF_IN;
                w_opnd = w_ch ? r_dry_r : r_dry_l;
            end
            STEP_WRITE_A: begin
                w_coef = COEF_FB;
                w_opnd = r_damp[i_line];
            end
            default: begin
                w_coef = '0;
                w_opnd = '0;
            end
        endcase
    end

    assign w_prod    = $signed({1'b0, w_coef}) * w_opnd;
    assign w_wr_data = sat24({r_acc[ACC_W-1], r_acc[ACC_W-1:16]});

    // wet output is half the summed taps, rounded towards plus infinity on ties
    assign w_half_l = (r_sum_l + SUM_W'(1)) >>> 1;
    assign w_half_r = (r_sum_r + SUM_W'(1)) >>> 1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= RATE_RESET;
        end else if (i_cfg_we) begin
            r_sample_rate <= i_cfg_data;
        end
    end

    // per-line state, cleared by reset or a clear transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_state) begin
            for (int k = 0; k < NUM_LINES; k++) begin
                r_pos[k]  <= '0;
                r_fill[k] <= '0;
                r_damp[k] <= '0;
            end
        end else begin
            unique case (i_cmd.step)
                STEP_DAMP_C: begin
                    r_damp[i_line] <= r_acc[DATA_W+15:16];
                end
                STEP_WRITE_B: begin
                    r_pos[i_line] <= (w_pos_next >= {1'b0, r_len}) ? '0
                                                                  : w_pos_next[POS_W-1:0];
                    if (r_cur_pos == r_fill[i_line]) begin
                        r_fill[i_line] <= w_pos_next[POS_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // delay store access
    always_ff @(posedge i_clk) begin
        if (i_cmd.step == STEP_READ) begin
            r_rdata <= mem[r_cur_addr];
        end
        if (i_cmd.step == STEP_WRITE_B) begin
            mem[r_cur_addr] <= w_wr_data;
        end
    end

    // length scaling, addressing and MAC sequence
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dry_l <= i_in_left;
            r_dry_r <= i_in_right;
            r_sum_l <= '0;
            r_sum_r <= '0;
        end
        unique case (i_cmd.step)
            STEP_LEN_MUL: begin
                r_prod <= PROD_W'(base_len(w_ch, 2'(w_j))) * PROD_W'(r_sample_rate);
            end
            STEP_LEN_DIV: begin
                r_quot <= w_recip_prod[46:32];
            end
            STEP_ADDR: begin
                r_len      <= w_len;
                r_cur_pos  <= w_pos_eff;
                r_cur_addr <= w_addr;
                r_valid    <= (w_pos_eff < r_fill[i_line]);
            end
            STEP_DAMP_A: begin
                r_tap <= w_tap;
                r_acc <= ACC_W'(w_prod) + ROUND_HALF;
                if (w_ch) begin
                    r_sum_r <= r_sum_r + SUM_W'(w_tap);
                end else begin
                    r_sum_l <= r_sum_l + SUM_W'(w_tap);
                end
            end
            STEP_DAMP_B: begin
                r_acc <= r_acc + ACC_W'(w_prod);
            end
            STEP_DAMP_C: begin
                r_acc <= ACC_W'(w_prod) + ROUND_HALF;
            end
            STEP_WRITE_A: begin
                r_acc <= r_acc + ACC_W'(w_prod);
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_left  <= sat24(28'(w_half_l));
            r_out_right <= sat24(28'(w_half_r));
        end
    end

    assign o_out_left  = r_out_left;
    assign o_out_right = r_out_right;

endmodule

// ===== rtl/core/sdcr_ctrl.sv =====
// sdcr_ctrl: sequencer over the comb lines and the channel handshakes
// depends on sdcr_pkg; commands sdcr_datapath through t_dp_cmd and the line index

module sdcr_ctrl #(
    parameter int LINES_PER_CHANNEL = 4,
    localparam int NUM_LINES        = 2 * LINES_PER_CHANNEL,
    localparam int LINE_W           = $clog2(NUM_LINES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_kind,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sdcr_pkg::t_dp_cmd     o_cmd,
    output logic [LINE_W-1:0]     o_line
);
    import sdcr_pkg::*;

    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(NUM_LINES - 1);

    t_ctrl_state       r_state;
    t_ctrl_state       n_state;
    logic [LINE_W-1:0] r_line;
    logic [LINE_W-1:0] n_line;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_accept;
    logic              w_out_free;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_kind == KIND_CLEAR) ? S_DONE : S_LEN_MUL;
                end
            end
            S_LEN_MUL: n_state = S_LEN_DIV;
            S_LEN_DIV: n_state = S_ADDR;
            S_ADDR:    n_state = S_READ;
            S_READ:    n_state = S_DAMP_A;
            S_DAMP_A:  n_state = S_DAMP_B;
            S_DAMP_B:  n_state = S_DAMP_C;
            S_DAMP_C:  n_state = S_WRITE_A;
            S_WRITE_A: n_state = S_WRITE_B;
            S_WRITE_B: n_state = (r_line == LAST_LINE) ? S_DONE : S_LEN_MUL;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // line counter and result valid flag
    always_comb begin
        n_line = r_line;
        if (r_state == S_WRITE_B) begin
            n_line = (r_line == LAST_LINE) ? '0 : r_line + LINE_W'(1);
        end
        n_out_valid = r_out_valid;
        if (r_state == S_DONE && w_out_free) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // outputs
    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.capture     = 1'b0;
        o_cmd.clear_state = 1'b0;
        o_cmd.load_out    = 1'b0;
        o_cmd.step        = STEP_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.capture     = i_in_valid;
                o_cmd.clear_state = i_in_valid && (i_in_kind == KIND_CLEAR);
            end
            S_LEN_MUL: o_cmd.step = STEP_LEN_MUL;
            S_LEN_DIV: o_cmd.step = STEP_LEN_DIV;
            S_ADDR:    o_cmd.step = STEP_ADDR;
            S_READ:    o_cmd.step = STEP_READ;
            S_DAMP_A:  o_cmd.step = STEP_DAMP_A;
            S_DAMP_B:  o_cmd.step = STEP_DAMP_B;
            S_DAMP_C:  o_cmd.step = STEP_DAMP_C;
            S_WRITE_A: o_cmd.step = STEP_WRITE_A;
            S_WRITE_B: o_cmd.step = STEP_WRITE_B;
            S_DONE:    o_cmd.load_out = w_out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_line      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_line      <= n_line;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_line      = r_line;
    assign o_out_valid = r_out_valid;

    // a sample transaction starts the line sequence
    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_kind == KIND_SAMPLE) |=> (r_state == S_LEN_MUL))
        else $error("sample transaction did not start the line sequence");

    // a clear transaction goes straight to the result
    a_clear_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_kind == KIND_CLEAR) |=> (r_state == S_DONE))
        else $error("clear transaction did not go straight to the result");

    // the line index stays within the bank
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line <= LAST_LINE))
        else $error("line index out of range");

    // every line sequence starts from the first line
    a_line_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_line == '0))
        else $error("line index not at the first line while idle");

    // a finished result is loaded and offered once the result register is free
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result was not offered");

endmodule
